FILE: sv/edt_pkg.sv
// shared constants, tables and types for the engine drivetrain tick block
package edt_pkg;

    localparam int TORQUE_POINTS = 11;
    localparam int GEAR_COUNT    = 5;

    localparam int SEG_W    = $clog2(TORQUE_POINTS);
    localparam int GIDX_W   = $clog2(GEAR_COUNT);
    localparam int GEAR_W   = 3;
    localparam int RPM_W    = 28;
    localparam int FORCE_W  = 24;
    localparam int TRQ_W    = 17;
    localparam int OFORCE_W = 20;
    localparam int X_W      = 22;
    localparam int RATIO_W  = 10;
    localparam int UP_W     = 21;
    localparam int CNT_W    = 9;

    localparam int BASE_W   = 24;
    localparam int FDR_W    = 12;
    localparam int FRIC_W   = 16;
    localparam int SHIFT_W  = 8;
    localparam int DSR_W    = 14;
    localparam int CIDX_W   = 3;
    localparam int CDATA_W  = 24;

    localparam int DIV_NW    = 40;
    localparam int DIV_DW    = 22;
    localparam int DIV_STEPS = DIV_NW / 2;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    localparam int MUL_AW = 28;
    localparam int MUL_BW = 17;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    localparam logic [RPM_W-1:0] RPM_MAX = 28'd255999744;

    // torque curve breakpoints, rpm and torque both q.8
    localparam logic [X_W-1:0] TRQ_X [TORQUE_POINTS] = '{
        22'd0, 22'd128000, 22'd256000, 22'd512000, 22'd768000, 22'd1024000,
        22'd1280000, 22'd1536000, 22'd1792000, 22'd2048000, 22'd2304000
    };
    localparam logic [TRQ_W-1:0] TRQ_Y [TORQUE_POINTS] = '{
        17'd0, 17'd4096, 17'd75520, 17'd101376, 17'd111360, 17'd101120,
        17'd86528, 17'd65792, 17'd51200, 17'd21760, 17'd2560
    };

    localparam logic [RATIO_W-1:0] RATIO_Q8 [GEAR_COUNT] = '{
        10'd640, 10'd512, 10'd435, 10'd333, 10'd282
    };
    localparam logic [UP_W-1:0] UP_RPM [GEAR_COUNT] = '{
        21'd1792000, 21'd1664000, 21'd1536000, 21'd1459200, 21'd0
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_DIV,
        S_LOAD_START,
        S_LOAD_WAIT,
        S_SEG,
        S_TRQ_MUL,
        S_TRQ_START,
        S_TRQ_WAIT,
        S_FORCE,
        S_DONE
    } state_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_BASE_LOAD     = 3'd0,
        CFG_FINAL_DRIVE   = 3'd1,
        CFG_FRICTION      = 3'd2,
        CFG_CLUTCH        = 3'd3,
        CFG_SHIFT_INT     = 3'd4,
        CFG_DOWNSHIFT_RPM = 3'd5
    } cfg_idx_t;

endpackage

FILE: sv/edt_div.sv
// shared iterative unsigned divider, two quotient bits per cycle
module edt_div
    import edt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_NW-1:0] dividend,
    input  logic [DIV_DW-1:0] divisor,
    output logic              done,
    output logic [DIV_NW-1:0] quotient
);

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DIV_CW-1:0] cnt_next;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] rem_next;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_NW-1:0] quo_next;
    logic [DIV_DW-1:0] div_reg;

    always_comb
    begin
        logic [DIV_DW:0]   r2;
        logic [DIV_DW-1:0] r;
        logic [DIV_NW-1:0] q;
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < 2; i++)
        begin
            r2 = {r, q[DIV_NW-1]};
            if (r2 >= {1'b0, div_reg})
            begin
                r2 = r2 - {1'b0, div_reg};
                q  = {q[DIV_NW-2:0], 1'b1};
            end
            else
            begin
                q = {q[DIV_NW-2:0], 1'b0};
            end
            r = r2[DIV_DW-1:0];
        end
        rem_next = r;
        quo_next = q;
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CW'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: sv/engine_drivetrain_tick.sv
// engine drivetrain tick: load, rpm update, torque lookup, output force, gearbox
// each transaction runs load division, rpm update, segment search, torque interpolation and
// output force (interpolation skipped when rpm is past the last torque point); one at a time
// the shared divider serves both the load and the torque interpolation
// a finished result waits in the output register while the next transaction is accepted
// reset: rpm 0, gear 0, countdown 20, registers to their defaults, no result pending
module engine_drivetrain_tick
    import edt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [FORCE_W-1:0]  burn_force,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [RPM_W-1:0]    engine_rpm,
    output logic [GEAR_W-1:0]   gear_now,
    output logic [TRQ_W-1:0]    engine_torque,
    output logic [OFORCE_W-1:0] wheel_force,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [CDATA_W-1:0]  cfg_data
);

    state_t state_reg;
    state_t state_next;

    // configuration
    logic [BASE_W-1:0]  base_load_reg;
    logic [FDR_W-1:0]   fdr_reg;
    logic [FRIC_W-1:0]  fric_reg;
    logic               clutch_reg;
    logic [SHIFT_W-1:0] shift_int_reg;
    logic [DSR_W-1:0]   dsr_reg;

    // tick state
    logic [RPM_W-1:0]        rpm_reg;
    logic [GEAR_W-1:0]       gear_reg;
    logic signed [CNT_W-1:0] cnt_reg;

    // working registers
    logic [FORCE_W-1:0] force_reg;
    logic [RPM_W-1:0]   rpm_new_reg;
    logic [RPM_W-1:0]   rpm_new_next;
    logic [SEG_W-1:0]   seg_reg;
    logic               neg_reg;
    logic [TRQ_W-1:0]   torque_reg;
    logic [TRQ_W-1:0]   torque_next;
    logic [MUL_PW-1:0]  mul_reg;

    // output register
    logic                out_valid_reg;
    logic [RPM_W-1:0]    out_rpm_reg;
    logic [GEAR_W-1:0]   out_gear_reg;
    logic [TRQ_W-1:0]    out_trq_reg;
    logic [OFORCE_W-1:0] out_force_reg;

    // control
    logic              mul_en;
    logic [MUL_AW-1:0] mul_a;
    logic [MUL_BW-1:0] mul_b;
    logic [MUL_PW-1:0] mul_p;
    logic              div_start;
    logic [DIV_NW-1:0] div_nd;
    logic [DIV_DW-1:0] div_dv;
    logic              div_done;
    logic [DIV_NW-1:0] div_quo;

    logic [GIDX_W-1:0]       gidx;
    logic [RATIO_W-1:0]      ratio;
    logic [SEG_W-1:0]        seg_find;
    logic [SEG_W-1:0]        seg_nx;
    logic                    past_last;
    logic [RPM_W-1:0]        dr;
    logic signed [TRQ_W:0]   dt;
    logic [TRQ_W-1:0]        dt_abs;
    logic [X_W-1:0]          dx;
    logic signed [41:0]      rpm_sum;
    logic signed [TRQ_W+1:0] trq_sum;
    logic signed [CNT_W-1:0] cnt_dec;
    logic [GEAR_W-1:0]       gear_shift;
    logic                    out_free;

    edt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_nd),
        .divisor  (div_dv),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign gidx     = (gear_reg < GEAR_W'(GEAR_COUNT)) ? gear_reg[GIDX_W-1:0]
                                                     : GIDX_W'(GEAR_COUNT - 1);
    assign ratio    = RATIO_Q8[gidx];
    assign seg_nx   = seg_reg + 1'b1;
    assign out_free = !out_valid_reg || !out_stall;
    assign mul_p    = mul_a * mul_b;

    // segment search over the torque curve
    always_comb
    begin
        seg_find  = '0;
        past_last = rpm_new_reg >= RPM_W'(TRQ_X[TORQUE_POINTS-1]);
        for (int i = 1; i < TORQUE_POINTS - 1; i++)
        begin
            if (rpm_new_reg >= RPM_W'(TRQ_X[i]))
            begin
                seg_find = SEG_W'(i);
            end
        end
    end

    always_comb
    begin
        dr     = rpm_new_reg - RPM_W'(TRQ_X[seg_reg]);
        dt     = $signed({1'b0, TRQ_Y[seg_nx]}) - $signed({1'b0, TRQ_Y[seg_reg]});
        dt_abs = dt[TRQ_W] ? TRQ_W'(-dt) : dt[TRQ_W-1:0];
        dx     = TRQ_X[seg_nx] - TRQ_X[seg_reg];
    end

    // rpm update with saturation
    always_comb
    begin
        rpm_sum = $signed({14'b0, rpm_reg}) + $signed({18'b0, force_reg})
                - $signed({14'b0, mul_reg[43:16]}) - $signed({2'b0, div_quo});
        if (rpm_sum < 0)
        begin
            rpm_new_next = '0;
        end
        else if (rpm_sum > $signed({14'b0, RPM_MAX}))
        begin
            rpm_new_next = RPM_MAX;
        end
        else
        begin
            rpm_new_next = rpm_sum[RPM_W-1:0];
        end
    end

    // torque from interpolation quotient
    always_comb
    begin
        if (neg_reg)
        begin
            trq_sum = $signed({2'b0, TRQ_Y[seg_reg]}) - $signed({2'b0, div_quo[TRQ_W-1:0]});
        end
        else
        begin
            trq_sum = $signed({2'b0, TRQ_Y[seg_reg]}) + $signed({2'b0, div_quo[TRQ_W-1:0]});
        end
        torque_next = (trq_sum < 0) ? '0 : trq_sum[TRQ_W-1:0];
    end

    // gearbox
    always_comb
    begin
        cnt_dec    = cnt_reg - 9'sd1;
        gear_shift = GEAR_W'(gidx);
        if ((gidx < GIDX_W'(GEAR_COUNT - 1)) && (rpm_new_reg > RPM_W'(UP_RPM[gidx])))
        begin
            gear_shift = GEAR_W'(gidx) + 1'b1;
        end
        else if ((gidx != '0) && (rpm_new_reg < {6'b0, dsr_reg, 8'b0}))
        begin
            gear_shift = GEAR_W'(gidx) - 1'b1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MUL_DIV;
                end
            end
            S_MUL_DIV:    state_next = S_LOAD_START;
            S_LOAD_START: state_next = S_LOAD_WAIT;
            S_LOAD_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_SEG;
                end
            end
            S_SEG:        state_next = past_last ? S_FORCE : S_TRQ_MUL;
            S_TRQ_MUL:    state_next = S_TRQ_START;
            S_TRQ_START:  state_next = S_TRQ_WAIT;
            S_TRQ_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_FORCE;
                end
            end
            S_FORCE:      state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:      state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall  = 1'b1;
        cfg_ready = 1'b1;
        mul_en    = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_nd    = '0;
        div_dv    = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
            end
            S_MUL_DIV:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_AW'(ratio);
                mul_b  = MUL_BW'(fdr_reg);
            end
            S_LOAD_START:
            begin
                mul_en    = 1'b1;
                mul_a     = rpm_reg;
                mul_b     = MUL_BW'(fric_reg);
                div_start = 1'b1;
                if (clutch_reg)
                begin
                    div_nd = {base_load_reg, 16'b0};
                    div_dv = mul_reg[DIV_DW-1:0];
                end
                else
                begin
                    div_nd = {8'b0, base_load_reg, 8'b0};
                    div_dv = DIV_DW'(ratio);
                end
            end
            S_TRQ_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = dr;
                mul_b  = dt_abs;
            end
            S_TRQ_START:
            begin
                div_start = 1'b1;
                div_nd    = mul_reg[DIV_NW-1:0];
                div_dv    = dx;
            end
            S_FORCE:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_AW'(ratio);
                mul_b  = torque_reg;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_load_reg <= 24'd128000;
            fdr_reg       <= 12'd512;
            fric_reg      <= 16'd3277;
            clutch_reg    <= 1'b1;
            shift_int_reg <= 8'd20;
            dsr_reg       <= 14'd1000;
            rpm_reg       <= '0;
            gear_reg      <= '0;
            cnt_reg       <= 9'sd20;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_BASE_LOAD:     base_load_reg <= cfg_data[BASE_W-1:0];
                    CFG_FINAL_DRIVE:   fdr_reg       <= cfg_data[FDR_W-1:0];
                    CFG_FRICTION:      fric_reg      <= cfg_data[FRIC_W-1:0];
                    CFG_CLUTCH:        clutch_reg    <= cfg_data[0];
                    CFG_SHIFT_INT:     shift_int_reg <= cfg_data[SHIFT_W-1:0];
                    CFG_DOWNSHIFT_RPM: dsr_reg       <= cfg_data[DSR_W-1:0];
                    default:           ;
                endcase
            end
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
                rpm_reg       <= rpm_new_reg;
                if (cnt_dec < 0)
                begin
                    gear_reg <= gear_shift;
                    cnt_reg  <= $signed({1'b0, shift_int_reg});
                end
                else
                begin
                    cnt_reg <= cnt_dec;
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && in_valid)
        begin
            force_reg <= burn_force;
        end
        if (mul_en)
        begin
            mul_reg <= mul_p;
        end
        if ((state_reg == S_LOAD_WAIT) && div_done)
        begin
            rpm_new_reg <= rpm_new_next;
        end
        if (state_reg == S_SEG)
        begin
            seg_reg <= seg_find;
            if (past_last)
            begin
                torque_reg <= TRQ_Y[TORQUE_POINTS-1];
            end
        end
        if (state_reg == S_TRQ_MUL)
        begin
            neg_reg <= dt[TRQ_W];
        end
        if ((state_reg == S_TRQ_WAIT) && div_done)
        begin
            torque_reg <= torque_next;
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            out_rpm_reg   <= rpm_new_reg;
            out_gear_reg  <= (cnt_dec < 0) ? gear_shift : GEAR_W'(gidx);
            out_trq_reg   <= torque_reg;
            out_force_reg <= mul_reg[OFORCE_W+6:7];
        end
    end

    assign out_valid     = out_valid_reg;
    assign engine_rpm    = out_rpm_reg;
    assign gear_now      = out_gear_reg;
    assign engine_torque = out_trq_reg;
    assign wheel_force   = out_force_reg;

endmodule

FILE: sv/edt_check.sv
// port-level checker for the engine drivetrain tick block, with its bind
module edt_check
    import edt_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic [RPM_W-1:0]    engine_rpm,
    input logic [GEAR_W-1:0]   gear_now,
    input logic [TRQ_W-1:0]    engine_torque,
    input logic [OFORCE_W-1:0] wheel_force
);

    // result holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(engine_rpm) && $stable(gear_now)
            && $stable(engine_torque) && $stable(wheel_force))
        else $error("stalled result changed or dropped");

    // block is busy right after taking a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted twice in a row");

    a_gear_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> gear_now < GEAR_W'(GEAR_COUNT))
        else $error("gear out of range");

    a_rpm_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> engine_rpm <= RPM_MAX)
        else $error("rpm above saturation limit");

    // a new result needs an accepted transaction first
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid ##1 out_valid |-> $past(in_stall))
        else $error("result appeared while idle");

endmodule

bind engine_drivetrain_tick edt_check u_edt_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .engine_rpm    (engine_rpm),
    .gear_now      (gear_now),
    .engine_torque (engine_torque),
    .wheel_force   (wheel_force)
);

FILE: tb/sv/engine_drivetrain_tick_tb.sv
// self-checking testbench for the engine drivetrain tick block
`timescale 1ns / 100ps

module engine_drivetrain_tick_tb
    import edt_pkg::*;
();

    localparam logic [CIDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CIDX_W-1:0] IDX_SPARE_HI = 3'd7;
    localparam int IDLE_MAX = 18;
    localparam logic [FORCE_W-1:0] FORCE_MAX = '1;
    localparam longint RPM_TOP  = 255999744;
    localparam longint LOAD_SAT = 64'h0000_0000_FFFF_FFFF;

    localparam longint BASE_LOAD_DEF = 128000;
    localparam longint BASE_LOAD_MAX = (64'd1 << BASE_W) - 1;
    localparam longint FDR_DEF       = 512;
    localparam longint FDR_MIN       = 256;
    localparam longint FDR_MAX       = (64'd1 << FDR_W) - 1;
    localparam longint FRIC_DEF      = 3277;
    localparam longint FRIC_MAX      = (64'd1 << FRIC_W) - 1;
    localparam longint SHIFT_DEF     = 20;
    localparam longint SHIFT_MAX     = (64'd1 << SHIFT_W) - 1;
    localparam longint DSR_DEF       = 1000;
    localparam longint DSR_MAX       = (64'd1 << DSR_W) - 1;

    // torque curve in whole rpm and whole torque units
    localparam longint CURVE_RPM [TORQUE_POINTS] = '{
        0, 500, 1000, 2000, 3000, 4000, 5000, 6000, 7000, 8000, 9000
    };
    localparam longint CURVE_TRQ [TORQUE_POINTS] = '{
        0, 16, 295, 396, 435, 395, 338, 257, 200, 85, 10
    };
    localparam longint GEAR_Q8 [GEAR_COUNT]     = '{640, 512, 435, 333, 282};
    localparam longint UPSHIFT_RPM [GEAR_COUNT] = '{7000, 6500, 6000, 5700, 0};

    typedef struct packed {
        logic [RPM_W-1:0]    rpm;
        logic [GEAR_W-1:0]   gear;
        logic [TRQ_W-1:0]    torque;
        logic [OFORCE_W-1:0] drive_force;
    } tick_out_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [FORCE_W-1:0]  burn_force = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [RPM_W-1:0]    engine_rpm;
    logic [GEAR_W-1:0]   gear_now;
    logic [TRQ_W-1:0]    engine_torque;
    logic [OFORCE_W-1:0] wheel_force;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CIDX_W-1:0]   cfg_index = '0;
    logic [CDATA_W-1:0]  cfg_data = '0;

    // predicted engine state and register copies
    longint pred_rpm;
    int     pred_gear;
    int     pred_countdown;
    longint reg_base_load;
    longint reg_final_drive;
    longint reg_friction;
    longint reg_clutch;
    longint reg_shift_int;
    longint reg_downshift;

    tick_out_t tick_results_due[$];
    int        error_count = 0;
    bit        no_idle = 1'b0;
    int        stall_left = 0;

    engine_drivetrain_tick i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .burn_force       (burn_force),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .engine_rpm       (engine_rpm),
        .gear_now         (gear_now),
        .engine_torque    (engine_torque),
        .wheel_force      (wheel_force),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void reset_predictor();
        pred_rpm        = 0;
        pred_gear       = 0;
        pred_countdown  = 20;
        reg_base_load   = BASE_LOAD_DEF;
        reg_final_drive = FDR_DEF;
        reg_friction    = FRIC_DEF;
        reg_clutch      = 1;
        reg_shift_int   = SHIFT_DEF;
        reg_downshift   = DSR_DEF;
    endfunction

    function automatic void apply_register(input logic [CIDX_W-1:0] idx,
                                           input logic [CDATA_W-1:0] data);
        case (idx)
            CFG_BASE_LOAD:     reg_base_load   = data[BASE_W-1:0];
            CFG_FINAL_DRIVE:   reg_final_drive = data[FDR_W-1:0];
            CFG_FRICTION:      reg_friction    = data[FRIC_W-1:0];
            CFG_CLUTCH:        reg_clutch      = data[0];
            CFG_SHIFT_INT:     reg_shift_int   = data[SHIFT_W-1:0];
            CFG_DOWNSHIFT_RPM: reg_downshift   = data[DSR_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic longint drivetrain_load();
        longint div;
        if (reg_clutch != 0)
        begin
            div = GEAR_Q8[pred_gear] * reg_final_drive;
            if (div == 0)
                return LOAD_SAT;
            return (reg_base_load << 16) / div;
        end
        return (reg_base_load << 8) / GEAR_Q8[pred_gear];
    endfunction

    function automatic longint friction_now();
        return (pred_rpm * reg_friction) >> 16;
    endfunction

    function automatic longint torque_of(input longint r);
        longint x0;
        longint x1;
        longint t0;
        longint t1;
        if (r >= CURVE_RPM[TORQUE_POINTS-1] * 256)
            return CURVE_TRQ[TORQUE_POINTS-1] * 256;
        for (int i = 0; i < TORQUE_POINTS - 1; i++)
        begin
            x0 = CURVE_RPM[i] * 256;
            x1 = CURVE_RPM[i+1] * 256;
            if (r >= x0 && r < x1)
            begin
                t0 = CURVE_TRQ[i] * 256;
                t1 = CURVE_TRQ[i+1] * 256;
                return t0 + ((t1 - t0) * (r - x0)) / (x1 - x0);
            end
        end
        return CURVE_TRQ[0] * 256;
    endfunction

    function automatic int gearbox_next(input longint r, input int g);
        if (g < GEAR_COUNT - 1 && r > UPSHIFT_RPM[g] * 256)
            return g + 1;
        if (g > 0 && r < reg_downshift * 256)
            return g - 1;
        return g;
    endfunction

    function automatic tick_out_t predict_tick(input logic [FORCE_W-1:0] f);
        tick_out_t res;
        longint    ratio;
        longint    rpm_new;
        longint    trq;
        longint    drv;
        ratio   = GEAR_Q8[pred_gear];
        rpm_new = pred_rpm + longint'(f) - friction_now() - drivetrain_load();
        if (rpm_new < 0)
            rpm_new = 0;
        else if (rpm_new > RPM_TOP)
            rpm_new = RPM_TOP;
        pred_rpm = rpm_new;
        trq = torque_of(pred_rpm);
        if (trq < 0)
            trq = 0;
        drv = (trq * ratio * 2) >> 8;
        pred_countdown--;
        if (pred_countdown < 0)
        begin
            pred_gear      = gearbox_next(pred_rpm, pred_gear);
            pred_countdown = int'(reg_shift_int);
        end
        res.rpm         = pred_rpm[RPM_W-1:0];
        res.gear        = pred_gear[GEAR_W-1:0];
        res.torque      = trq[TRQ_W-1:0];
        res.drive_force = drv[OFORCE_W-1:0];
        return res;
    endfunction

    // combustion force that lands the next tick on the given rpm, where reachable
    function automatic logic [FORCE_W-1:0] force_to_reach(input longint goal);
        longint need;
        need = goal - pred_rpm + friction_now() + drivetrain_load();
        if (need < 0)
            need = 0;
        else if (need > longint'(FORCE_MAX))
            need = longint'(FORCE_MAX);
        return need[FORCE_W-1:0];
    endfunction

    function automatic int idle_cycles();
        if (no_idle)
            return 0;
        return int'($urandom_range(0, IDLE_MAX));
    endfunction

    // field value in the low bits, random junk above it
    function automatic logic [CDATA_W-1:0] with_noise(input longint val, input int width);
        logic [CDATA_W-1:0] mask;
        mask = {CDATA_W{1'b1}} >> (CDATA_W - width);
        return (CDATA_W'($urandom) & ~mask) | (CDATA_W'(val) & mask);
    endfunction

    function automatic longint pick_value(input longint lo, input longint hi,
                                          input longint dflt, input longint span);
        case ($urandom_range(0, 4))
            0: return lo;
            1: return hi;
            2: return dflt;
            default: return longint'($urandom_range(span, lo));
        endcase
    endfunction

    function automatic void compare_field(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            error_count++;
        end
    endfunction

    task automatic send_tick(input logic [FORCE_W-1:0] f);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        burn_force <= f;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tick_results_due.push_back(predict_tick(f));
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_register(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_registers(input longint base, input longint fdr, input longint fric,
                                 input longint clutch, input longint shift,
                                 input longint dsr);
        write_reg(CFG_BASE_LOAD, with_noise(base, BASE_W));
        write_reg(CFG_FINAL_DRIVE, with_noise(fdr, FDR_W));
        write_reg(CFG_FRICTION, with_noise(fric, FRIC_W));
        write_reg(CFG_CLUTCH, with_noise(clutch, 1));
        write_reg(CFG_SHIFT_INT, with_noise(shift, SHIFT_W));
        write_reg(CFG_DOWNSHIFT_RPM, with_noise(dsr, DSR_W));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (tick_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // reset defaults: zero force, every breakpoint hit exactly, past the curve, full force, just above a breakpoint
    task automatic test_torque_curve();
        send_tick('0);
        for (int i = 0; i < TORQUE_POINTS; i++)
            send_tick(force_to_reach(CURVE_RPM[i] * 256));
        send_tick(force_to_reach((CURVE_RPM[TORQUE_POINTS-1] + 700) * 256));
        send_tick(FORCE_MAX);
        send_tick(force_to_reach(CURVE_RPM[2] * 256 + 1));
    endtask

    // zero final drive, open clutch, writes to unused indexes
    task automatic test_load_special();
        drain();
        write_reg(CFG_FINAL_DRIVE, with_noise(0, FDR_W));
        send_tick(FORCE_MAX);
        send_tick(FORCE_W'($urandom));
        drain();
        write_reg(CFG_CLUTCH, with_noise(0, 1));
        write_reg(CFG_FINAL_DRIVE, with_noise(FDR_DEF, FDR_W));
        send_tick(force_to_reach(3000 * 256));
        send_tick(force_to_reach(3500 * 256));
        drain();
        write_reg(IDX_SPARE_LO, CDATA_W'($urandom));
        write_reg(IDX_SPARE_HI, CDATA_W'($urandom));
        send_tick(force_to_reach(2000 * 256));
    endtask

    // evaluate every tick, ramp through all gears and back down
    task automatic test_gearbox_sweep();
        longint goal;
        drain();
        set_registers(BASE_LOAD_DEF, FDR_DEF, FRIC_DEF, 1, 0, DSR_DEF);
        goal = 0;
        while (goal < 9200 * 256)
        begin
            goal += longint'($urandom_range(100, 300)) * 256;
            send_tick(force_to_reach(goal));
        end
        while (goal > 0)
        begin
            goal -= longint'($urandom_range(100, 300)) * 256;
            if (goal < 0)
                goal = 0;
            send_tick(force_to_reach(goal));
        end
        repeat (6) send_tick(force_to_reach(300 * 256));
    endtask

    task automatic test_random_settings();
        longint walk;
        int     dir;
        int     kind;
        int     pt;
        logic [FORCE_W-1:0] f;
        for (int phase = 0; phase < 20; phase++)
        begin
            drain();
            if (phase == 0)
                set_registers(BASE_LOAD_MAX, FDR_MAX, FRIC_MAX, 1, SHIFT_MAX, DSR_MAX);
            else if (phase == 1)
                set_registers(0, FDR_MIN, 0, 0, 0, 0);
            else
                set_registers(pick_value(0, BASE_LOAD_MAX, BASE_LOAD_DEF, 400000),
                              ($urandom_range(0, 9) == 0) ? 0 :
                                  pick_value(FDR_MIN, FDR_MAX, FDR_DEF, FDR_MAX),
                              pick_value(0, FRIC_MAX, FRIC_DEF, FRIC_MAX),
                              longint'($urandom_range(0, 1)),
                              pick_value(0, SHIFT_MAX, SHIFT_DEF, 40),
                              pick_value(0, DSR_MAX, DSR_DEF, 6000));
            if ($urandom_range(0, 2) == 0)
                write_reg(CIDX_W'(IDX_SPARE_LO + $urandom_range(0, 1)), CDATA_W'($urandom));
            no_idle = (phase % 4 == 3);
            walk = pred_rpm;
            dir  = 1;
            repeat (65)
            begin
                kind = int'($urandom_range(0, 9));
                if (kind <= 5)
                begin
                    if ($urandom_range(0, 19) == 0)
                        dir = -dir;
                    walk += longint'(dir * int'($urandom_range(0, 400))) * 256;
                    if (walk > 9800 * 256)
                    begin
                        walk = 9800 * 256;
                        dir  = -1;
                    end
                    else if (walk < 0)
                    begin
                        walk = 0;
                        dir  = 1;
                    end
                    f = force_to_reach(walk);
                end
                else if (kind <= 7)
                begin
                    pt = int'($urandom_range(0, TORQUE_POINTS - 1));
                    f = force_to_reach(CURVE_RPM[pt] * 256 + int'($urandom_range(0, 4)) - 2);
                end
                else if (kind == 8)
                    f = FORCE_W'($urandom);
                else
                    f = ($urandom_range(0, 1) == 1) ? FORCE_MAX : '0;
                send_tick(f);
            end
        end
        no_idle = 1'b0;
    endtask

    // result side: random stall between transactions, check against oldest prediction
    always @(posedge clk)
    begin : result_check
        tick_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (tick_results_due.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual rpm %0d gear %0d",
                         $time, engine_rpm, gear_now);
                error_count++;
            end
            else
            begin
                want = tick_results_due.pop_front();
                compare_field("engine_rpm", 32'(want.rpm), 32'(engine_rpm));
                compare_field("gear_now", 32'(want.gear), 32'(gear_now));
                compare_field("engine_torque", 32'(want.torque), 32'(engine_torque));
                compare_field("wheel_force", 32'(want.drive_force), 32'(wheel_force));
            end
            stall_left = idle_cycles();
        end
        else if (stall_left > 0)
        begin
            stall_left--;
        end
        out_stall <= (stall_left != 0);
    end

    initial
    begin
        #(20_000_000);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        reset_predictor();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_torque_curve();
        test_load_special();
        test_gearbox_sweep();
        test_random_settings();
        drain();
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
sv/edt_pkg.sv
sv/edt_div.sv
sv/engine_drivetrain_tick.sv
sv/edt_check.sv
tb/sv/engine_drivetrain_tick_tb.sv
